// ===== rtl/core/ffba_pkg.sv =====
// ffba_pkg: shared types, codes and defaults of the first-fit block allocator
// used by every module under rtl/core except ffba_ram; depends on nothing

package ffba_pkg;

    localparam int MAX_BLOCKS_DEF  = 64;
    localparam int ENTRY_BYTES_DEF = 16;

    localparam int SIZE_W = 32;
    localparam int ADDR_W = 33;
    localparam int STAT_W = 2;

    localparam logic [SIZE_W-1:0] HEAP_BASE_RST  = 32'h0070_0000;
    localparam logic [SIZE_W-1:0] HEAP_BYTES_RST = 32'd100000;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] start;
        logic [SIZE_W-1:0] length;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ASCAN,
        ST_IPREP,
        ST_ISHIFT,
        ST_IWRITE,
        ST_ATAIL,
        ST_RSCAN,
        ST_RSHIFT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_ENT_NEXT,
        RD_LAST,
        RD_SH_DOWN,
        RD_SH_UP
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DOWN,
        WR_NEW
    } wr_sel_t;

    typedef struct packed {
        logic              idle;
        logic              load_req;
        rd_sel_t           rd_sel;
        wr_sel_t           wr_sel;
        logic              ent_inc;
        logic              cursor_adv;
        logic              pos_from_ent;
        logic              pos_from_count;
        logic              sh_load_last;
        logic              sh_load_ent_next;
        logic              sh_dec;
        logic              sh_inc;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              res_set;
        logic              res_grant;
        logic [STAT_W-1:0] res_code;
        logic              push_out;
    } dp_ctl_t;

    typedef struct packed {
        logic req_release;
        logic count_zero;
        logic full;
        logic fit;
        logic addr_gt;
        logic addr_eq;
        logic ent_last;
        logic sh_at_pos;
        logic sh_last;
        logic tail_ok;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/core/first_fit_block_allocator.sv =====
// first_fit_block_allocator: top level of the first-fit block allocator
// depends on ffba_pkg, ffba_ctrl, ffba_dp (which holds ffba_ram)
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------
//  request  | req_valid/req_stall  | cmd, req_size, req_address
//  response | rsp_valid/rsp_stall  | grant_address, status
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  a request walks the block table through the single read port of the
//  table ram, one entry a cycle, then shifts entries one a cycle
//  allocate: scan, shift up, then write of the new entry; release: scan, then shift down
//  no clearing pass after reset: the table is filled by count only
//  the next request is taken while a response waits under rsp_stall

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
    parameter int ENTRY_BYTES = ENTRY_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              cmd,
    input  logic [SIZE_W-1:0] req_size,
    input  logic [ADDR_W-1:0] req_address,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [ADDR_W-1:0] grant_address,
    output logic [STAT_W-1:0] status
);

    dp_ctl_t ctl;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;
    assign req_stall = !ctl.idle;

    ffba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .ctl       (ctl)
    );

    ffba_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .req_size      (req_size),
        .req_address   (req_address),
        .rsp_stall     (rsp_stall),
        .ctl           (ctl),
        .sts           (sts),
        .rsp_valid     (rsp_valid),
        .grant_address (grant_address),
        .status        (status)
    );

endmodule

// ===== rtl/core/ffba_ram.sv =====
// ffba_ram: generic single-write, single-read ram with registered read data
// depends on nothing

module ffba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ffba_ctrl.sv =====
// ffba_ctrl: request sequencer of the allocator (scan, shift, insert, remove)
// depends on ffba_pkg; drives ffba_dp through dp_ctl_t, reads dp_sts_t

module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  dp_sts_t sts,
    output dp_ctl_t ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (sts.req_release)
                    begin
                        state_next = sts.count_zero ? ST_DONE : ST_RSCAN;
                    end
                    else if (sts.full)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = sts.count_zero ? ST_ATAIL : ST_ASCAN;
                    end
                end
            end
            ST_ASCAN:
            begin
                if (sts.fit)
                begin
                    state_next = ST_IPREP;
                end
                else if (sts.ent_last)
                begin
                    state_next = ST_ATAIL;
                end
            end
            ST_IPREP:
            begin
                state_next = ST_ISHIFT;
            end
            ST_ISHIFT:
            begin
                if (sts.sh_at_pos)
                begin
                    state_next = ST_IWRITE;
                end
            end
            ST_IWRITE:
            begin
                state_next = ST_DONE;
            end
            ST_ATAIL:
            begin
                state_next = sts.tail_ok ? ST_IWRITE : ST_DONE;
            end
            ST_RSCAN:
            begin
                priority if (sts.addr_gt)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.addr_eq)
                begin
                    state_next = sts.ent_last ? ST_DONE : ST_RSHIFT;
                end
                else if (sts.ent_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RSHIFT:
            begin
                if (sts.sh_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.rd_sel = RD_ZERO;
        ctl.wr_sel = WR_NONE;
        ctl.res_code = STATUS_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.idle = 1'b1;
                if (req_valid)
                begin
                    ctl.load_req = 1'b1;
                    if (sts.req_release && sts.count_zero)
                    begin
                        ctl.res_set = 1'b1;
                        ctl.res_code = STATUS_NOT_FOUND;
                    end
                    else if (!sts.req_release && sts.full)
                    begin
                        ctl.res_set = 1'b1;
                        ctl.res_code = STATUS_NO_SPACE;
                    end
                end
            end
            ST_ASCAN:
            begin
                ctl.rd_sel = RD_ENT_NEXT;
                if (sts.fit)
                begin
                    ctl.pos_from_ent = 1'b1;
                end
                else
                begin
                    ctl.cursor_adv = 1'b1;
                    ctl.ent_inc = !sts.ent_last;
                end
            end
            ST_IPREP:
            begin
                ctl.rd_sel = RD_LAST;
                ctl.sh_load_last = 1'b1;
            end
            ST_ISHIFT:
            begin
                ctl.rd_sel = RD_SH_DOWN;
                ctl.wr_sel = WR_UP;
                ctl.sh_dec = !sts.sh_at_pos;
            end
            ST_IWRITE:
            begin
                ctl.wr_sel = WR_NEW;
                ctl.cnt_inc = 1'b1;
                ctl.res_set = 1'b1;
                ctl.res_grant = 1'b1;
                ctl.res_code = STATUS_OK;
            end
            ST_ATAIL:
            begin
                if (sts.tail_ok)
                begin
                    ctl.pos_from_count = 1'b1;
                end
                else
                begin
                    ctl.res_set = 1'b1;
                    ctl.res_code = STATUS_NO_SPACE;
                end
            end
            ST_RSCAN:
            begin
                ctl.rd_sel = RD_ENT_NEXT;
                priority if (sts.addr_gt)
                begin
                    ctl.res_set = 1'b1;
                    ctl.res_code = STATUS_NOT_FOUND;
                end
                else if (sts.addr_eq)
                begin
                    if (sts.ent_last)
                    begin
                        ctl.cnt_dec = 1'b1;
                        ctl.res_set = 1'b1;
                        ctl.res_code = STATUS_OK;
                    end
                    else
                    begin
                        ctl.sh_load_ent_next = 1'b1;
                    end
                end
                else if (sts.ent_last)
                begin
                    ctl.res_set = 1'b1;
                    ctl.res_code = STATUS_NOT_FOUND;
                end
                else
                begin
                    ctl.ent_inc = 1'b1;
                end
            end
            ST_RSHIFT:
            begin
                ctl.rd_sel = RD_SH_UP;
                ctl.wr_sel = WR_DOWN;
                if (sts.sh_last)
                begin
                    ctl.cnt_dec = 1'b1;
                    ctl.res_set = 1'b1;
                    ctl.res_code = STATUS_OK;
                end
                else
                begin
                    ctl.sh_inc = 1'b1;
                end
            end
            ST_DONE:
            begin
                ctl.push_out = sts.out_free;
            end
            default:
            begin
                ctl.idle = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/ffba_dp.sv =====
// ffba_dp: allocator datapath (config registers, block table ram, cursor,
// index counters, compares, result and output registers)
// depends on ffba_pkg and ffba_ram

module ffba_dp
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
    parameter int ENTRY_BYTES = ENTRY_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              cmd,
    input  logic [SIZE_W-1:0] req_size,
    input  logic [ADDR_W-1:0] req_address,
    input  logic              rsp_stall,
    input  dp_ctl_t           ctl,
    output dp_sts_t           sts,
    output logic              rsp_valid,
    output logic [ADDR_W-1:0] grant_address,
    output logic [STAT_W-1:0] status
);

    localparam int AW     = $clog2(MAX_BLOCKS);
    localparam int CW     = $clog2(MAX_BLOCKS + 1);
    localparam int FOOT_W = CW + 9;
    localparam int SUM_W  = ((FOOT_W > ADDR_W + 1) ? FOOT_W : ADDR_W + 1) + 2;
    localparam int EW     = $bits(entry_t);

    logic [SIZE_W-1:0] base_reg, bytes_reg;
    logic [CW-1:0]     count_reg;
    logic [AW-1:0]     ent_reg, pos_reg, sh_reg;
    logic [ADDR_W-1:0] cursor_reg, addr_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SUM_W-1:0]  spf_reg;
    logic [ADDR_W-1:0] res_grant_reg, grant_reg;
    logic [STAT_W-1:0] res_code_reg, status_reg;
    logic              rsp_valid_reg;

    logic [CW-1:0]     count_m1;
    logic [FOOT_W-1:0] foot;
    logic [AW-1:0]     raddr, waddr;
    logic              we;
    logic [EW-1:0]     rdata, wdata;
    entry_t            rd_entry, new_entry;
    logic [ADDR_W-1:0] s_ext, base_ext, gap, addr_abs, grant_sum;
    logic [SUM_W-1:0]  need;

    assign count_m1  = count_reg - CW'(1);
    assign foot      = FOOT_W'(ENTRY_BYTES) * (FOOT_W'(count_reg) + FOOT_W'(2));
    assign rd_entry  = entry_t'(rdata);
    assign s_ext     = {1'b0, rd_entry.start};
    assign base_ext  = {1'b0, base_reg};
    assign gap       = s_ext - cursor_reg;
    assign addr_abs  = base_ext + s_ext;
    assign grant_sum = base_ext + cursor_reg;
    assign need      = SUM_W'(cursor_reg) + spf_reg;

    assign new_entry.start  = cursor_reg[SIZE_W-1:0];
    assign new_entry.length = size_reg;

    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_ZERO:     raddr = '0;
            RD_ENT_NEXT: raddr = ent_reg + AW'(1);
            RD_LAST:     raddr = count_m1[AW-1:0];
            RD_SH_DOWN:  raddr = sh_reg - AW'(1);
            RD_SH_UP:    raddr = sh_reg + AW'(1);
            default:     raddr = '0;
        endcase
    end

    always_comb
    begin
        we    = 1'b1;
        waddr = pos_reg;
        wdata = rdata;
        unique case (ctl.wr_sel)
            WR_NONE:
            begin
                we = 1'b0;
            end
            WR_UP:
            begin
                waddr = sh_reg + AW'(1);
            end
            WR_DOWN:
            begin
                waddr = sh_reg - AW'(1);
            end
            WR_NEW:
            begin
                wdata = EW'(new_entry);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    ffba_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        sts.req_release = (cmd == CMD_RELEASE);
        sts.count_zero  = (count_reg == '0);
        sts.full        = (count_reg == CW'(MAX_BLOCKS));
        sts.fit         = (s_ext >= cursor_reg) && (gap >= {1'b0, size_reg});
        sts.addr_gt     = (addr_abs > addr_reg);
        sts.addr_eq     = (addr_abs == addr_reg);
        sts.ent_last    = (CW'(ent_reg) == count_m1);
        sts.sh_at_pos   = (sh_reg == pos_reg);
        sts.sh_last     = (CW'(sh_reg) == count_m1);
        sts.tail_ok     = !(SUM_W'(bytes_reg) < need);
        sts.out_free    = !rsp_valid_reg || !rsp_stall;
    end

    // config registers and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= HEAP_BASE_RST;
            bytes_reg     <= HEAP_BYTES_RST;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_HEAP_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else
                begin
                    bytes_reg <= cfg_data;
                end
            end
            if (ctl.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (ctl.cnt_dec)
            begin
                count_reg <= count_m1;
            end
            if (ctl.push_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            size_reg   <= req_size;
            addr_reg   <= req_address;
            spf_reg    <= SUM_W'(req_size) + SUM_W'(foot);
            cursor_reg <= '0;
            ent_reg    <= '0;
        end
        else
        begin
            if (ctl.cursor_adv)
            begin
                cursor_reg <= s_ext + {1'b0, rd_entry.length};
            end
            if (ctl.ent_inc)
            begin
                ent_reg <= ent_reg + AW'(1);
            end
        end
        if (ctl.pos_from_ent)
        begin
            pos_reg <= ent_reg;
        end
        else if (ctl.pos_from_count)
        begin
            pos_reg <= count_reg[AW-1:0];
        end
        priority if (ctl.sh_load_last)
        begin
            sh_reg <= count_m1[AW-1:0];
        end
        else if (ctl.sh_load_ent_next)
        begin
            sh_reg <= ent_reg + AW'(1);
        end
        else if (ctl.sh_dec)
        begin
            sh_reg <= sh_reg - AW'(1);
        end
        else if (ctl.sh_inc)
        begin
            sh_reg <= sh_reg + AW'(1);
        end
        if (ctl.res_set)
        begin
            res_code_reg  <= ctl.res_code;
            res_grant_reg <= ctl.res_grant ? grant_sum : '0;
        end
        if (ctl.push_out)
        begin
            grant_reg  <= res_grant_reg;
            status_reg <= res_code_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign grant_address = grant_reg;
    assign status        = status_reg;

endmodule

// ===== rtl/core/ffba_checker.sv =====
// ffba_checker: port-level assertions of the allocator, bound to the top level
// depends on ffba_pkg and first_fit_block_allocator

module ffba_checker
    import ffba_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input logic [ADDR_W-1:0] grant_address,
    input logic [STAT_W-1:0] status
);

    // a held response word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(grant_address) && $stable(status))
        else $error("response word changed under stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == STATUS_OK) || (status == STATUS_NO_SPACE)
                      || (status == STATUS_NOT_FOUND))
        else $error("undefined status code");

    // failed requests grant nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != STATUS_OK) |-> grant_address == '0)
        else $error("grant address on failed request");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while busy");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .grant_address (grant_address),
    .status        (status)
);

// ===== sim/first_fit_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// first_fit_block_allocator_tb: self-checking bench for first_fit_block_allocator
// directed table then random allocate/release words, checked against an inline block table model
// depends on ffba_pkg and first_fit_block_allocator

module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    localparam int NBLK           = MAX_BLOCKS_DEF;
    localparam int ENTRY          = ENTRY_BYTES_DEF;
    localparam int PHASE_ITEMS    = 260;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int DIR_ROWS       = 17;

    typedef struct packed {
        logic [ADDR_W-1:0] grant;
        logic [STAT_W-1:0] status;
    } response_t;

    typedef struct {
        logic              c;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        response_t         rsp;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [SIZE_W-1:0] cfg_data;
    logic              req_valid;
    logic              req_stall;
    logic              cmd;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] req_address;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [ADDR_W-1:0] grant_address;
    logic [STAT_W-1:0] status;

    logic [SIZE_W-1:0] tbl_start [NBLK];
    logic [SIZE_W-1:0] tbl_len   [NBLK];
    int                tbl_count;
    logic [SIZE_W-1:0] cur_heap_base;
    logic [SIZE_W-1:0] cur_heap_bytes;

    response_t         pending_rsp [$];
    response_t         exp_rsp;
    dir_row_t          dir_rows [DIR_ROWS];
    int                errors = 0;
    int                quiet_cycles = 0;
    bit                no_idle = 1'b0;
    bit                hold_req = 1'b0;

    first_fit_block_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .cmd          (cmd),
        .req_size     (req_size),
        .req_address  (req_address),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .grant_address(grant_address),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void table_insert(int pos, logic [SIZE_W-1:0] off,
                                         logic [SIZE_W-1:0] len);
        for (int k = tbl_count; k > pos; k--)
        begin
            tbl_start[k] = tbl_start[k-1];
            tbl_len[k]   = tbl_len[k-1];
        end
        tbl_start[pos] = off;
        tbl_len[pos]   = len;
        tbl_count++;
    endfunction

    function automatic response_t predict_response(logic c, logic [SIZE_W-1:0] sz,
                                                   logic [ADDR_W-1:0] ad);
        response_t         r;
        longint unsigned   cursor;
        longint unsigned   s;
        longint            avail;
        longint            need;
        logic [ADDR_W-1:0] a;
        bit                room;
        r.grant  = '0;
        r.status = STATUS_OK;
        cursor   = 0;
        room     = tbl_count < NBLK;
        if (c == CMD_ALLOC)
        begin
            for (int i = 0; i < tbl_count; i++)
            begin
                s = tbl_start[i];
                if (room && s >= cursor && s - cursor >= sz)
                begin
                    table_insert(i, cursor[SIZE_W-1:0], sz);
                    r.grant = {1'b0, cur_heap_base} + cursor[ADDR_W-1:0];
                    return r;
                end
                cursor = s + tbl_len[i];
            end
            // tail placement: signed, exact comparison
            avail = cur_heap_bytes;
            avail = avail - ENTRY * (tbl_count + 1) - longint'(cursor);
            need  = sz;
            need  = need + ENTRY;
            if (!room || avail < need)
                r.status = STATUS_NO_SPACE;
            else
            begin
                table_insert(tbl_count, cursor[SIZE_W-1:0], sz);
                r.grant = {1'b0, cur_heap_base} + cursor[ADDR_W-1:0];
            end
        end
        else
        begin
            r.status = STATUS_NOT_FOUND;
            for (int i = 0; i < tbl_count; i++)
            begin
                a = {1'b0, cur_heap_base} + {1'b0, tbl_start[i]};
                if (a > ad)
                    return r;
                if (a == ad)
                begin
                    for (int k = i; k + 1 < tbl_count; k++)
                    begin
                        tbl_start[k] = tbl_start[k+1];
                        tbl_len[k]   = tbl_len[k+1];
                    end
                    tbl_count--;
                    r.status = STATUS_OK;
                    return r;
                end
            end
        end
        return r;
    endfunction

    // bytes left for a block placed after the last entry
    function automatic longint tail_room_bytes();
        longint room;
        room = cur_heap_bytes;
        room = room - ENTRY * (tbl_count + 2);
        if (tbl_count > 0)
            room = room - longint'(tbl_start[tbl_count-1]) - longint'(tbl_len[tbl_count-1]);
        return room;
    endfunction

    task automatic offer_request(logic c, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ad,
                                 bit typed, response_t typed_rsp);
        response_t r;
        while (!no_idle && $urandom_range(99) < 20)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        cmd         <= c;
        req_size    <= sz;
        req_address <= ad;
        do @(posedge clk); while (req_stall);
        r = predict_response(c, sz, ad);
        pending_rsp.push_back(typed ? typed_rsp : r);
        @(negedge clk);
    endtask

    task automatic random_request(int alloc_pct, int small_max);
        logic              c;
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] ad;
        longint            room;
        int                pick;
        response_t         none;
        none = '0;
        sz   = $urandom;
        ad   = {1'($urandom_range(1)), 32'($urandom)};
        if ($urandom_range(99) < alloc_pct)
        begin
            c    = CMD_ALLOC;
            pick = $urandom_range(99);
            room = tail_room_bytes();
            if (pick < 10)
                sz = '0;
            else if (pick < 20 && room >= 0)
                sz = room[SIZE_W-1:0] + 32'($urandom_range(1));
            else if (pick < 30)
                sz = $urandom;
            else if (pick < 33)
                sz = '1;
            else
                sz = $urandom_range(small_max);
        end
        else
        begin
            c = CMD_RELEASE;
            if (tbl_count > 0 && $urandom_range(99) < 80)
            begin
                ad = {1'b0, cur_heap_base} + {1'b0, tbl_start[$urandom_range(tbl_count-1)]};
                if ($urandom_range(99) < 10)
                    ad = ad + ($urandom_range(1) ? 33'd1 : -33'd1);
            end
        end
        offer_request(c, sz, ad, 1'b0, none);
    endtask

    task automatic write_register(logic idx, logic [SIZE_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_HEAP_BASE)
            cur_heap_base = d;
        else
            cur_heap_bytes = d;
        @(negedge clk);
    endtask

    task automatic run_phase(logic [SIZE_W-1:0] base, logic [SIZE_W-1:0] bytes,
                             int alloc_pct, int small_max);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        @(negedge clk);
        write_register(CFG_HEAP_BASE, base);
        write_register(CFG_HEAP_BYTES, bytes);
        cfg_valid <= 1'b0;
        for (int n = 0; n < PHASE_ITEMS; n++)
            random_request(alloc_pct, small_max);
    endtask

    // response side stall, with one long hold-off on request
    initial
    begin
        int hold_left;
        rsp_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
                rsp_stall <= !no_idle && ($urandom_range(99) < 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response word with nothing pending: grant_address %h status %0d",
                       grant_address, status);
                errors++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (grant_address !== exp_rsp.grant)
                begin
                    $error("grant_address expected %h actual %h", exp_rsp.grant, grant_address);
                    errors++;
                end
                if (status !== exp_rsp.status)
                begin
                    $error("status expected %0d actual %0d", exp_rsp.status, status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_HEAP_BASE;
        cfg_data       = '0;
        req_valid      = 1'b0;
        cmd            = CMD_ALLOC;
        req_size       = '0;
        req_address    = '0;
        cur_heap_base  = HEAP_BASE_RST;
        cur_heap_bytes = HEAP_BYTES_RST;
        tbl_count      = 0;

        // directed rows, some typed: empty table, reset heap, oversize and out-of-range requests
        dir_rows = '{
            '{CMD_RELEASE, 32'd0,          33'h0_0070_0000, 1'b1, '{33'd0, STATUS_NOT_FOUND}},
            '{CMD_ALLOC,   32'd0,          33'h1_FFFF_FFFF, 1'b1,
              '{33'h0_0070_0000, STATUS_OK}},
            '{CMD_ALLOC,   32'd100,        33'd0,           1'b0, '{33'd0, STATUS_OK}},
            '{CMD_ALLOC,   32'hFFFF_FFFF,  33'd0,           1'b1, '{33'd0, STATUS_NO_SPACE}},
            '{CMD_ALLOC,   32'd1000,       33'd0,           1'b0, '{33'd0, STATUS_OK}},
            '{CMD_RELEASE, 32'hFFFF_FFFF,  33'h0_0070_0000, 1'b0, '{33'd0, STATUS_OK}},
            '{CMD_RELEASE, 32'd0,          33'h0_0070_0001, 1'b0, '{33'd0, STATUS_OK}},
            '{CMD_RELEASE, 32'd0,          33'h1_FFFF_FFFF, 1'b1, '{33'd0, STATUS_NOT_FOUND}},
            '{CMD_ALLOC,   32'd98000,      33'd0,           1'b0, '{33'd0, STATUS_OK}},
            '{CMD_RELEASE, 32'd0,          33'h0_0070_0000, 1'b0, '{33'd0, STATUS_OK}},
            '{CMD_ALLOC,   32'd50,         33'd0,           1'b0, '{33'd0, STATUS_OK}},
            '{CMD_ALLOC,   32'd50,         33'd0,           1'b0, '{33'd0, STATUS_OK}},
            '{CMD_ALLOC,   32'd0,          33'd0,           1'b0, '{33'd0, STATUS_OK}},
            '{CMD_RELEASE, 32'd0,          33'd0,           1'b1, '{33'd0, STATUS_NOT_FOUND}},
            '{CMD_ALLOC,   32'd1,          33'd0,           1'b0, '{33'd0, STATUS_OK}},
            '{CMD_ALLOC,   32'h7FFF_FFFF,  33'd0,           1'b1, '{33'd0, STATUS_NO_SPACE}},
            '{CMD_RELEASE, 32'd0,          33'h1_0070_0000, 1'b0, '{33'd0, STATUS_OK}}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            offer_request(dir_rows[i].c, dir_rows[i].size, dir_rows[i].addr,
                          dir_rows[i].typed, dir_rows[i].rsp);

        hold_req = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++)
            random_request(60, 4000);

        no_idle = 1'b1;
        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 90, 2000);
        no_idle = 1'b0;
        run_phase(32'hFFFF_FFFF, 32'd3000, 40, 600);
        run_phase($urandom, 32'd0, 50, 1000);
        run_phase(HEAP_BASE_RST, HEAP_BYTES_RST, 55, 3000);

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
